### rtl/core/npcf_pkg.sv
// Shared types, widths and helpers for the neighbour pair cutoff filter.
// No dependencies; imported by every module in rtl/core.
package npcf_pkg;

    localparam int COORD_BITS = 24;
    localparam int NUM_KINDS  = 2;

    localparam int LEN_W      = 24;
    localparam int REACH_W    = 48;
    localparam int TAG_W      = 24;
    localparam int INDEX_W    = 24;
    localparam int CFG_DATA_W = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int DIMS_W     = 2;

    localparam int DIFF_W   = COORD_BITS + 1;
    localparam int FOLD_W   = ((DIFF_W > LEN_W + 1) ? DIFF_W : LEN_W + 1) + 2;
    localparam int SQ_IN_W  = 26;
    localparam int MAG_W    = (FOLD_W - 1 > SQ_IN_W + 1) ? FOLD_W - 1 : SQ_IN_W + 1;
    localparam int SQ_W     = 2 * SQ_IN_W + 1;
    localparam int RR_W     = SQ_W + 2;
    localparam int LANE_LAT = 4;

    localparam logic [SQ_W-1:0]   SQ_CAP   = {1'b1, {(2 * SQ_IN_W){1'b0}}};
    localparam logic              KIND_MAX = 1'(NUM_KINDS - 1);
    localparam logic [DIMS_W-1:0] DIMS_2D  = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BOX_X    = 3'd0,
        REG_BOX_Y    = 3'd1,
        REG_BOX_Z    = 3'd2,
        REG_REACH_AA = 3'd3,
        REG_REACH_AB = 3'd4,
        REG_REACH_BB = 3'd5,
        REG_DIMS     = 3'd6
    } reg_idx_t;

    typedef enum logic [1:0] {
        REACH_AA,
        REACH_AB,
        REACH_BB
    } reach_sel_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] owner_x;
        logic signed [COORD_BITS-1:0] owner_y;
        logic signed [COORD_BITS-1:0] owner_z;
        logic signed [COORD_BITS-1:0] partner_x;
        logic signed [COORD_BITS-1:0] partner_y;
        logic signed [COORD_BITS-1:0] partner_z;
        logic                         owner_kind;
        logic                         partner_kind;
        logic [TAG_W-1:0]             owner_tag;
        logic [TAG_W-1:0]             partner_tag;
        logic                         home_cell;
        logic [INDEX_W-1:0]           partner_index;
    } pair_req_t;

    typedef struct packed {
        logic [INDEX_W-1:0] neighbour_index;
        logic [REACH_W-1:0] distance_sq;
    } pair_res_t;

    typedef struct packed {
        logic [LEN_W-1:0]   box_len_x;
        logic [LEN_W-1:0]   box_len_y;
        logic [LEN_W-1:0]   box_len_z;
        logic [REACH_W-1:0] reach_sq_aa;
        logic [REACH_W-1:0] reach_sq_ab;
        logic [REACH_W-1:0] reach_sq_bb;
        logic [DIMS_W-1:0]  dims;
    } cfg_t;

    function automatic logic eff_kind(input logic k);
        return (k > KIND_MAX) ? KIND_MAX : k;
    endfunction

endpackage

### rtl/core/npcf_cfg.sv
// Configuration register file: box edges, squared reach per kind pair, dimension.
// Depends on npcf_pkg.
module npcf_cfg
    import npcf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_BOX_X:    cfg_next.box_len_x   = wr_data[LEN_W-1:0];
                REG_BOX_Y:    cfg_next.box_len_y   = wr_data[LEN_W-1:0];
                REG_BOX_Z:    cfg_next.box_len_z   = wr_data[LEN_W-1:0];
                REG_REACH_AA: cfg_next.reach_sq_aa = wr_data[REACH_W-1:0];
                REG_REACH_AB: cfg_next.reach_sq_ab = wr_data[REACH_W-1:0];
                REG_REACH_BB: cfg_next.reach_sq_bb = wr_data[REACH_W-1:0];
                REG_DIMS:     cfg_next.dims        = wr_data[DIMS_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.box_len_x   <= '1;
            cfg_reg.box_len_y   <= '1;
            cfg_reg.box_len_z   <= '1;
            cfg_reg.reach_sq_aa <= '0;
            cfg_reg.reach_sq_ab <= '0;
            cfg_reg.reach_sq_bb <= '0;
            cfg_reg.dims        <= 2'd3;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/core/npcf_axis.sv
// One axis lane: difference, minimum-image fold, magnitude, saturating square.
// Four register stages. Depends on npcf_pkg.
module npcf_axis
    import npcf_pkg::*;
(
    input  logic                         clk,
    input  logic signed [COORD_BITS-1:0] owner_pos,
    input  logic signed [COORD_BITS-1:0] partner_pos,
    input  logic [LEN_W-1:0]             box_len,
    output logic [SQ_W-1:0]              sq
);

    logic signed [DIFF_W-1:0] diff_reg;
    logic signed [DIFF_W-1:0] diff_next;
    logic signed [FOLD_W-1:0] fold_reg;
    logic signed [FOLD_W-1:0] fold_next;
    logic [SQ_IN_W-1:0]       mag_reg;
    logic [SQ_IN_W-1:0]       mag_next;
    logic                     sat_reg;
    logic                     sat_next;
    logic [SQ_W-1:0]          sq_reg;
    logic [SQ_W-1:0]          sq_next;

    logic signed [FOLD_W-1:0] d_ext;
    logic signed [FOLD_W-1:0] d_dbl;
    logic signed [FOLD_W-1:0] len_s;
    logic signed [FOLD_W-1:0] abs_val;
    logic [MAG_W-1:0]         mag_full;
    logic [2*SQ_IN_W-1:0]     prod;

    assign diff_next = DIFF_W'(owner_pos) - DIFF_W'(partner_pos);

    always_comb
    begin
        d_ext = FOLD_W'(diff_reg);
        d_dbl = d_ext <<< 1;
        len_s = signed'(FOLD_W'(box_len));
        if (d_dbl > len_s)
            fold_next = d_ext - len_s;
        else if (d_dbl < -len_s)
            fold_next = d_ext + len_s;
        else
            fold_next = d_ext;
    end

    always_comb
    begin
        abs_val  = (fold_reg < 0) ? -fold_reg : fold_reg;
        mag_full = MAG_W'(unsigned'(abs_val[FOLD_W-2:0]));
        sat_next = |mag_full[MAG_W-1:SQ_IN_W];
        mag_next = mag_full[SQ_IN_W-1:0];
    end

    assign prod    = mag_reg * mag_reg;
    assign sq_next = sat_reg ? SQ_CAP : {1'b0, prod};

    always_ff @(posedge clk)
    begin
        diff_reg <= diff_next;
        fold_reg <= fold_next;
        mag_reg  <= mag_next;
        sat_reg  <= sat_next;
        sq_reg   <= sq_next;
    end

    assign sq = sq_reg;

endmodule

### rtl/core/neighbour_pair_cutoff_filter_top.sv
// Top level of the neighbour pair cutoff filter: request intake, axis lanes, reach test.
// Depends on npcf_pkg, npcf_cfg, npcf_axis.
//
// Takes one candidate pair per clock whenever busy is low; busy is high only
// for the first clock after reset. A request accepted at one edge produces its
// result (if the pair survives the same-cell rule and lies strictly inside the
// reach) as a one-cycle result_strobe after four stages in each axis lane
// (difference, fold, magnitude, square) and one stage for the sum and reach
// compare. Results come out in request order and cannot be held off.
// Write configuration only with no request in flight, i.e. five idle clocks
// after the last accepted request.
module neighbour_pair_cutoff_filter_top
    import npcf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  pair_req_t             item,
    output logic                  result_strobe,
    output pair_res_t             result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t cfg;

    logic up_reg;

    logic       valid_reg     [LANE_LAT];
    logic [INDEX_W-1:0] index_reg [LANE_LAT];
    reach_sel_t reach_sel_reg [LANE_LAT];

    logic       valid_next;
    reach_sel_t reach_sel_next;
    logic       ka;
    logic       kb;
    logic       drop;

    logic [SQ_W-1:0]    sq_x;
    logic [SQ_W-1:0]    sq_y;
    logic [SQ_W-1:0]    sq_z;
    logic [RR_W-1:0]    rr;
    logic [REACH_W-1:0] reach;
    logic               hit;

    logic      strobe_reg;
    pair_res_t result_reg;
    pair_res_t result_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            up_reg <= 1'b0;
        else
            up_reg <= 1'b1;
    end

    assign busy      = !up_reg;
    assign cfg_ready = up_reg;

    npcf_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // same-cell rule and reach selection
    always_comb
    begin
        ka   = eff_kind(item.owner_kind);
        kb   = eff_kind(item.partner_kind);
        drop = item.home_cell && (kb <= ka) && (item.partner_tag <= item.owner_tag);
        valid_next = start && !busy && !drop;
        if (ka != kb)
            reach_sel_next = REACH_AB;
        else if (ka == 1'b0)
            reach_sel_next = REACH_AA;
        else
            reach_sel_next = REACH_BB;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LANE_LAT; i++)
                valid_reg[i] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= valid_next;
            for (int i = 1; i < LANE_LAT; i++)
                valid_reg[i] <= valid_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        index_reg[0]     <= item.partner_index;
        reach_sel_reg[0] <= reach_sel_next;
        for (int i = 1; i < LANE_LAT; i++)
        begin
            index_reg[i]     <= index_reg[i-1];
            reach_sel_reg[i] <= reach_sel_reg[i-1];
        end
    end

    npcf_axis u_axis_x (
        .clk         (clk),
        .owner_pos   (item.owner_x),
        .partner_pos (item.partner_x),
        .box_len     (cfg.box_len_x),
        .sq          (sq_x)
    );

    npcf_axis u_axis_y (
        .clk         (clk),
        .owner_pos   (item.owner_y),
        .partner_pos (item.partner_y),
        .box_len     (cfg.box_len_y),
        .sq          (sq_y)
    );

    npcf_axis u_axis_z (
        .clk         (clk),
        .owner_pos   (item.owner_z),
        .partner_pos (item.partner_z),
        .box_len     (cfg.box_len_z),
        .sq          (sq_z)
    );

    always_comb
    begin
        rr = RR_W'(sq_x) + RR_W'(sq_y) + ((cfg.dims != DIMS_2D) ? RR_W'(sq_z) : '0);
        unique case (reach_sel_reg[LANE_LAT-1])
            REACH_AA: reach = cfg.reach_sq_aa;
            REACH_AB: reach = cfg.reach_sq_ab;
            REACH_BB: reach = cfg.reach_sq_bb;
            default:  reach = cfg.reach_sq_bb;
        endcase
        hit = valid_reg[LANE_LAT-1] && (rr < RR_W'(reach));
        result_next.neighbour_index = index_reg[LANE_LAT-1];
        result_next.distance_sq     = rr[REACH_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            strobe_reg <= 1'b0;
        else
            strobe_reg <= hit;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_strobe = strobe_reg;
    assign result        = result_reg;

endmodule

### rtl/core/npcf_checker.sv
// Port-level checker for the neighbour pair cutoff filter, bound to the top level.
// Depends on npcf_pkg and neighbour_pair_cutoff_filter_top.
module npcf_checker
    import npcf_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      start,
    input logic      busy,
    input pair_req_t item,
    input logic      result_strobe
);

    // once up, the block never stops taking requests
    assert property (@(posedge clk) disable iff (!rst_n) !busy |=> !busy)
        else $error("busy rose after start-up");

    // every result traces back to an earlier accepted request
    assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> $past(start && !busy, 5))
        else $error("result without matching request");

    // same-cell pair with partner not above owner gives no result
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.home_cell
            && (item.partner_kind <= item.owner_kind)
            && (item.partner_tag <= item.owner_tag))
        |-> ##5 !result_strobe)
        else $error("dropped same-cell pair produced a result");

endmodule

bind neighbour_pair_cutoff_filter_top npcf_checker u_npcf_checker (.*);
